// File: rtl/core/swet_pkg.sv
// Shared types, codes and arithmetic helpers for the stopwatch elapsed-time block.
package swet_pkg;

   localparam logic [2:0] KIND_START   = 3'd0;
   localparam logic [2:0] KIND_SUSPEND = 3'd1;
   localparam logic [2:0] KIND_RESUME  = 3'd2;
   localparam logic [2:0] KIND_STOP    = 3'd3;
   localparam logic [2:0] KIND_SAMPLE  = 3'd4;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_SUSP = 2'd2;

   // 24 hours in 1/256 s ticks
   localparam logic [31:0] TICKS_PER_DAY = 32'd22118400;

   // floor(q / 225) == (q * HOUR_RECIP) >> 28 for any 20-bit q
   localparam logic [20:0] HOUR_RECIP = 21'd1193047;
   // floor(x / 3) == (x * THIRD_RECIP) >> 11 for x < 600
   localparam logic [9:0]  THIRD_RECIP = 10'd683;
   // floor(x / 15) == (x * FIFTEENTH_RECIP) >> 16 for x < 900
   localparam logic [12:0] FIFTEENTH_RECIP = 13'd4370;

   localparam logic [7:0] TENTH_EDGE [9] = '{8'd25, 8'd51, 8'd76, 8'd102, 8'd128,
                                             8'd154, 8'd180, 8'd205, 8'd230};

   typedef struct packed {
      logic [2:0] kind;
      logic [4:0] clock_hours;
      logic [5:0] clock_minutes;
      logic [5:0] clock_seconds;
      logic [7:0] subsecond_raw;
      logic       day_changed;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] run_state;
      logic [4:0] elapsed_hours;
      logic [5:0] elapsed_minutes;
      logic [5:0] elapsed_seconds;
      logic [3:0] elapsed_tenths;
      logic       overflow;
   } rsp_payload_type;

   // Count to display plus the status that rides along with it
   typedef struct packed {
      logic [1:0]  run_state;
      logic        overflow;
      logic [31:0] ticks;
   } shown_type;

   // Clock time in ticks; the low byte of (secs << 8) is zero, so the
   // fraction 255 - raw just fills it.
   function automatic logic [25:0] clock_ticks(input logic [5:0] h, input logic [5:0] m,
                                               input logic [5:0] s, input logic [7:0] raw);
      logic [17:0] secs;
      secs = 18'(h) * 18'd3600 + 18'(m) * 18'd60 + 18'(s);
      return {secs, ~raw};
   endfunction

   function automatic logic [3:0] tenths_of(input logic [7:0] frac);
      logic [3:0] cnt;
      cnt = 4'd0;
      for (int i = 0; i < 9; i++) begin
         if (frac >= TENTH_EDGE[i]) begin
            cnt = cnt + 4'd1;
         end
      end
      return cnt;
   endfunction

endpackage

// File: rtl/core/stopwatch_elapsed_time_top.sv
// Stopwatch elapsed-time block: input register, state update, display pipeline.
// Path: a request transfer enters the input register, and the state update then feeds
//   five display stages, the last being the output register.
// Throughput: one transfer per cycle; a stalled result holds the whole pipeline.
// Reset (synchronous): state goes idle, mark and counts clear, pipeline empties.
module stopwatch_elapsed_time_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  swet_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output swet_pkg::rsp_payload_type rsp_payload
);

   logic                      advance;
   logic                      step;

   logic                      req_vld_ff;
   swet_pkg::req_payload_type req_ff;

   logic [1:0]  run_state_ff, run_state_in;
   logic [24:0] start_mark_ff, start_mark_in;
   logic [31:0] banked_ff, banked_in;
   logic [31:0] running_ff, running_in;

   logic [25:0]         mark_ticks;
   logic [5:0]          now_hours;
   logic [25:0]         now_ticks;
   logic [31:0]         run_sum;
   logic                ovf;
   swet_pkg::shown_type shown;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign step      = req_vld_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (advance) begin
         req_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
   end

   always_comb begin
      mark_ticks = swet_pkg::clock_ticks({1'b0, req_ff.clock_hours}, req_ff.clock_minutes,
                                         req_ff.clock_seconds, req_ff.subsecond_raw);
      // a date change since the mark counts as a further 24 hours
      now_hours  = {1'b0, req_ff.clock_hours} + (req_ff.day_changed ? 6'd24 : 6'd0);
      now_ticks  = swet_pkg::clock_ticks(now_hours, req_ff.clock_minutes,
                                         req_ff.clock_seconds, req_ff.subsecond_raw);
      run_sum    = 32'(now_ticks) - 32'(start_mark_ff) + banked_ff;

      run_state_in  = run_state_ff;
      start_mark_in = start_mark_ff;
      banked_in     = banked_ff;
      running_in    = running_ff;
      ovf           = 1'b0;

      unique case (req_ff.kind)
         swet_pkg::KIND_START: begin
            if (run_state_ff == swet_pkg::ST_IDLE) begin
               start_mark_in = mark_ticks[24:0];
               banked_in     = '0;
               running_in    = '0;
               run_state_in  = swet_pkg::ST_RUN;
            end
         end
         swet_pkg::KIND_SUSPEND: begin
            if (run_state_ff == swet_pkg::ST_RUN) begin
               banked_in    = running_ff;
               running_in   = '0;
               run_state_in = swet_pkg::ST_SUSP;
            end
         end
         swet_pkg::KIND_RESUME: begin
            start_mark_in = mark_ticks[24:0];
            run_state_in  = swet_pkg::ST_RUN;
         end
         swet_pkg::KIND_STOP: begin
            run_state_in = swet_pkg::ST_IDLE;
         end
         swet_pkg::KIND_SAMPLE: begin
            if (run_state_ff == swet_pkg::ST_RUN) begin
               running_in = run_sum;
               if (run_sum >= swet_pkg::TICKS_PER_DAY) begin
                  ovf          = 1'b1;
                  run_state_in = swet_pkg::ST_IDLE;
               end
            end
         end
         default: begin
         end
      endcase

      shown.run_state = run_state_in;
      shown.overflow  = ovf;
      unique case (run_state_in)
         swet_pkg::ST_RUN:  shown.ticks = running_in;
         swet_pkg::ST_SUSP: shown.ticks = banked_in;
         default:           shown.ticks = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_state_ff  <= swet_pkg::ST_IDLE;
         start_mark_ff <= '0;
         banked_ff     <= '0;
         running_ff    <= '0;
      end else if (step) begin
         run_state_ff  <= run_state_in;
         start_mark_ff <= start_mark_in;
         banked_ff     <= banked_in;
         running_ff    <= running_in;
      end
   end

   swet_disp u_disp (
      .clock       (clock),
      .reset       (reset),
      .en          (advance),
      .in_valid    (req_vld_ff),
      .in_shown    (shown),
      .out_valid   (rsp_valid),
      .out_payload (rsp_payload)
   );

   a_ovf_goes_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.overflow |-> rsp_payload.run_state == swet_pkg::ST_IDLE)
      else $error("overflow result does not report idle");

   a_idle_shows_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.run_state == swet_pkg::ST_IDLE |->
         rsp_payload.elapsed_hours == 5'd0 && rsp_payload.elapsed_minutes == 6'd0 &&
         rsp_payload.elapsed_seconds == 6'd0 && rsp_payload.elapsed_tenths == 4'd0)
      else $error("idle result shows a nonzero count");

   a_suspend_banks: assert property (@(posedge clock) disable iff (reset)
      run_state_ff == swet_pkg::ST_RUN ##1 run_state_ff == swet_pkg::ST_SUSP |->
         running_ff == 32'd0 && banked_ff == $past(running_ff))
      else $error("suspend did not bank the running count");

endmodule

// File: rtl/core/swet_disp.sv
// Pipelined conversion of a tick count into hh:mm:ss and tenths.
module swet_disp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  swet_pkg::shown_type      in_shown,
   output logic                     out_valid,
   output swet_pkg::rsp_payload_type out_payload
);

   // stage 1: count captured
   logic        v1_ff;
   logic [1:0]  st1_ff;
   logic        ovf1_ff;
   logic [31:0] t1_ff;

   // stage 2: total hours
   logic        v2_ff;
   logic [1:0]  st2_ff;
   logic        ovf2_ff;
   logic [19:0] q2_ff;
   logic [11:0] low2_ff;
   logic [12:0] hrs2_ff;

   // stage 3: tick remainder within the hour, hours / 24
   logic        v3_ff;
   logic [1:0]  st3_ff;
   logic        ovf3_ff;
   logic [11:0] low3_ff;
   logic [12:0] hrs3_ff;
   logic [7:0]  rem3_ff;
   logic [7:0]  hdiv3_ff;

   // stage 4: hours mod 24, minutes
   logic        v4_ff;
   logic [1:0]  st4_ff;
   logic        ovf4_ff;
   logic [9:0]  low4_ff;
   logic [4:0]  hmod4_ff;
   logic [9:0]  x4_ff;
   logic [5:0]  mins4_ff;

   // output register
   logic                      v5_ff;
   swet_pkg::rsp_payload_type out_ff;

   logic [40:0] hrs_prod;
   logic [12:0] hrs2_in;
   logic [20:0] rem_prod;
   logic [7:0]  rem3_in;
   logic [19:0] hdiv_prod;
   logic [7:0]  hdiv3_in;
   logic [12:0] hsub;
   logic [4:0]  hmod4_in;
   logic [9:0]  x4_in;
   logic [22:0] min_prod;
   logic [5:0]  mins4_in;
   logic [9:0]  sec_sub;
   swet_pkg::rsp_payload_type out_in;

   always_comb begin
      hrs_prod  = 41'(t1_ff[31:12]) * 41'(swet_pkg::HOUR_RECIP);
      hrs2_in   = hrs_prod[40:28];

      rem_prod  = 21'(hrs2_ff) * 21'd225;
      rem3_in   = 8'(21'(q2_ff) - rem_prod);
      hdiv_prod = 20'(hrs2_ff[12:3]) * 20'(swet_pkg::THIRD_RECIP);
      hdiv3_in  = hdiv_prod[18:11];

      hsub      = hrs3_ff - 13'(hdiv3_ff) * 13'd24;
      hmod4_in  = hsub[4:0];
      x4_in     = {rem3_ff, low3_ff[11:10]};
      min_prod  = 23'(x4_in) * 23'(swet_pkg::FIFTEENTH_RECIP);
      mins4_in  = min_prod[21:16];

      sec_sub                = x4_ff - 10'(mins4_ff) * 10'd15;
      out_in.run_state       = st4_ff;
      out_in.elapsed_hours   = hmod4_ff;
      out_in.elapsed_minutes = mins4_ff;
      out_in.elapsed_seconds = {sec_sub[3:0], low4_ff[9:8]};
      out_in.elapsed_tenths  = swet_pkg::tenths_of(low4_ff[7:0]);
      out_in.overflow        = ovf4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st1_ff   <= in_shown.run_state;
         ovf1_ff  <= in_shown.overflow;
         t1_ff    <= in_shown.ticks;

         st2_ff   <= st1_ff;
         ovf2_ff  <= ovf1_ff;
         q2_ff    <= t1_ff[31:12];
         low2_ff  <= t1_ff[11:0];
         hrs2_ff  <= hrs2_in;

         st3_ff   <= st2_ff;
         ovf3_ff  <= ovf2_ff;
         low3_ff  <= low2_ff;
         hrs3_ff  <= hrs2_ff;
         rem3_ff  <= rem3_in;
         hdiv3_ff <= hdiv3_in;

         st4_ff   <= st3_ff;
         ovf4_ff  <= ovf3_ff;
         low4_ff  <= low3_ff[9:0];
         hmod4_ff <= hmod4_in;
         x4_ff    <= x4_in;
         mins4_ff <= mins4_in;

         out_ff   <= out_in;
      end
   end

   assign out_valid   = v5_ff;
   assign out_payload = out_ff;

endmodule

// File: test/stopwatch_elapsed_time_checker.sv
// Checker for the stopwatch block: predicts each response and compares it with the DUT.
`timescale 1ns / 1ps

module stopwatch_elapsed_time_checker
   import swet_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   output int              fail_count,
   output int              pending_count
);

   localparam logic [31:0] HOUR_TICKS = 32'd3600 << 8;
   localparam logic [31:0] MIN_TICKS  = 32'd60 << 8;
   localparam logic [31:0] DAY_TICKS  = 32'd86400 << 8;
   localparam logic [7:0]  TENTHS_STEP [9] = '{8'd25, 8'd51, 8'd76, 8'd102, 8'd128,
                                               8'd154, 8'd180, 8'd205, 8'd230};

   // stopwatch model state
   logic [1:0]  sw_state;
   logic [24:0] sw_mark;
   logic [31:0] sw_banked;
   logic [31:0] sw_running;

   rsp_payload_type elapsed_q[$];
   int mismatch_total = 0;
   int waiting_total = 0;

   assign fail_count    = mismatch_total;
   assign pending_count = waiting_total;

   function automatic logic [31:0] time_ticks(input logic [5:0] h, input logic [5:0] m,
                                              input logic [5:0] s, input logic [7:0] raw);
      return ((32'(h) * 32'd3600 + 32'(m) * 32'd60 + 32'(s)) << 8) + 32'(8'hff - raw);
   endfunction

   function automatic rsp_payload_type format_elapsed(input logic [1:0] st,
                                                      input logic [31:0] t,
                                                      input logic ovf);
      rsp_payload_type r;
      logic [31:0] hours;
      logic [31:0] rem;
      logic [31:0] mins;
      logic [31:0] frac;
      logic [3:0]  tenths;
      hours = t / HOUR_TICKS;
      rem   = t % HOUR_TICKS;
      mins  = rem / MIN_TICKS;
      rem   = rem % MIN_TICKS;
      frac  = rem & 32'hff;
      tenths = 4'd0;
      for (int i = 0; i < 9; i++) begin
         if (frac >= 32'(TENTHS_STEP[i])) begin
            tenths = 4'(i + 1);
         end
      end
      r.run_state       = st;
      r.elapsed_hours   = 5'(hours % 32'd24);
      r.elapsed_minutes = 6'(mins);
      r.elapsed_seconds = 6'(rem >> 8);
      r.elapsed_tenths  = tenths;
      r.overflow        = ovf;
      return r;
   endfunction

   task automatic predict_elapsed(input req_payload_type r, output rsp_payload_type e);
      logic        ovf;
      logic [5:0]  hh;
      logic [31:0] shown;
      ovf = 1'b0;
      case (r.kind)
         KIND_START: begin
            if (sw_state == ST_IDLE) begin
               sw_mark    = 25'(time_ticks(6'(r.clock_hours), r.clock_minutes,
                                           r.clock_seconds, r.subsecond_raw));
               sw_banked  = '0;
               sw_running = '0;
               sw_state   = ST_RUN;
            end
         end
         KIND_SUSPEND: begin
            if (sw_state == ST_RUN) begin
               sw_banked  = sw_running;
               sw_running = '0;
               sw_state   = ST_SUSP;
            end
         end
         KIND_RESUME: begin
            // recaptures the mark from any state; banked count is kept
            sw_mark  = 25'(time_ticks(6'(r.clock_hours), r.clock_minutes,
                                      r.clock_seconds, r.subsecond_raw));
            sw_state = ST_RUN;
         end
         KIND_STOP: begin
            sw_state = ST_IDLE;
         end
         KIND_SAMPLE: begin
            if (sw_state == ST_RUN) begin
               hh = 6'(r.clock_hours) + (r.day_changed ? 6'd24 : 6'd0);
               sw_running = time_ticks(hh, r.clock_minutes, r.clock_seconds, r.subsecond_raw)
                            - 32'(sw_mark) + sw_banked;
               if (sw_running >= DAY_TICKS) begin
                  ovf      = 1'b1;
                  sw_state = ST_IDLE;
               end
            end
         end
         default: begin
         end
      endcase
      case (sw_state)
         ST_RUN:  shown = sw_running;
         ST_SUSP: shown = sw_banked;
         default: shown = '0;
      endcase
      e = format_elapsed(sw_state, shown, ovf);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_total++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_payload_type predicted;
      rsp_payload_type oldest;
      if (reset) begin
         sw_state   = ST_IDLE;
         sw_mark    = '0;
         sw_banked  = '0;
         sw_running = '0;
         elapsed_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            predict_elapsed(req_payload, predicted);
            elapsed_q.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (elapsed_q.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatch_total++;
            end else begin
               oldest = elapsed_q.pop_front();
               check_field("run_state", oldest.run_state, rsp_payload.run_state);
               check_field("elapsed_hours", oldest.elapsed_hours, rsp_payload.elapsed_hours);
               check_field("elapsed_minutes", oldest.elapsed_minutes,
                           rsp_payload.elapsed_minutes);
               check_field("elapsed_seconds", oldest.elapsed_seconds,
                           rsp_payload.elapsed_seconds);
               check_field("elapsed_tenths", oldest.elapsed_tenths, rsp_payload.elapsed_tenths);
               check_field("overflow", oldest.overflow, rsp_payload.overflow);
            end
         end
      end
      waiting_total = elapsed_q.size();
   end

endmodule

// File: test/stopwatch_elapsed_time_top_tb.sv
// Testbench top for the stopwatch block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module stopwatch_elapsed_time_top_tb;
   import swet_pkg::*;

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          RANDOM_ITEMS = 1500;
   localparam int unsigned DAY_TICKS    = 86400 * 256;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   int              fail_count;
   int              pending_count;

   // sender burst bookkeeping and a wall clock for well-formed sessions
   int          burst_left = 0;
   int          counted_items = 0;
   int unsigned wall_ticks = 0;
   int          wall_day = 0;
   int          mark_day = 0;
   int          rx_cycle = 0;

   stopwatch_elapsed_time_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   stopwatch_elapsed_time_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // receiver: steps through four stall modes in turn
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle++;
         case ((rx_cycle / 150) % 4)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= ($urandom_range(0, 9) > 6);
            default: rsp_ready <= ((rx_cycle % 7) > 1);
         endcase
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("stopwatch_elapsed_time_top_tb NOT OK");
      $finish;
   end

   function automatic req_payload_type clock_req(input logic [2:0] kind, input int h,
                                                 input int m, input int s, input int raw,
                                                 input bit dc);
      req_payload_type r;
      r.kind          = kind;
      r.clock_hours   = 5'(h);
      r.clock_minutes = 6'(m);
      r.clock_seconds = 6'(s);
      r.subsecond_raw = 8'(raw);
      r.day_changed   = dc;
      return r;
   endfunction

   function automatic req_payload_type wall_req(input logic [2:0] kind);
      int unsigned rem;
      rem = wall_ticks % 921600;
      return clock_req(kind, wall_ticks / 921600, rem / 15360, (rem % 15360) >> 8,
                       255 - (rem & 255), wall_day != mark_day);
   endfunction

   function automatic req_payload_type noise_req();
      return clock_req(3'($urandom_range(0, 7)), $urandom_range(0, 31), $urandom_range(0, 63),
                       $urandom_range(0, 63), $urandom_range(0, 255), 1'($urandom_range(0, 1)));
   endfunction

   task automatic advance_wall();
      int unsigned step;
      if ($urandom_range(0, 19) == 0) begin
         step = $urandom_range(0, 2 * DAY_TICKS);
      end else if ($urandom_range(0, 4) == 0) begin
         step = $urandom_range(0, 200000);
      end else begin
         step = $urandom_range(0, 40);
      end
      wall_ticks += step;
      while (wall_ticks >= DAY_TICKS) begin
         wall_ticks -= DAY_TICKS;
         wall_day++;
      end
   endtask

   // drive at the falling edge, hold until the transfer
   task automatic send_req(input req_payload_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 10);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      if (item.kind <= KIND_SAMPLE) begin
         counted_items++;
      end
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic run_session();
      int steps;
      int pick;
      steps = $urandom_range(3, 40);
      advance_wall();
      mark_day = wall_day;
      send_req(wall_req(KIND_START));
      for (int i = 0; i < steps; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            advance_wall();
            send_req(wall_req(KIND_SAMPLE));
         end else if (pick < 78) begin
            send_req(wall_req(KIND_SUSPEND));
         end else if (pick < 86) begin
            advance_wall();
            mark_day = wall_day;
            send_req(wall_req(KIND_RESUME));
         end else if (pick < 94) begin
            send_req(noise_req());
         end else begin
            send_req(wall_req(KIND_START));
         end
      end
      if ($urandom_range(0, 3) != 0) begin
         send_req(wall_req(KIND_STOP));
      end
   endtask

   initial begin
      bit drained;
      drained     = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: edges of the count, ignored commands, overflow paths
      send_req(clock_req(KIND_SAMPLE, 0, 0, 0, 255, 1'b0));
      send_req(clock_req(KIND_START, 0, 0, 0, 255, 1'b0));
      send_req(clock_req(KIND_SAMPLE, 23, 59, 59, 0, 1'b0));
      send_req(clock_req(KIND_SUSPEND, 0, 0, 0, 0, 1'b0));
      send_req(clock_req(KIND_SUSPEND, 1, 1, 1, 1, 1'b0));
      send_req(clock_req(KIND_SAMPLE, 5, 5, 5, 5, 1'b0));
      send_req(clock_req(KIND_START, 3, 3, 3, 3, 1'b0));
      send_req(clock_req(KIND_RESUME, 0, 0, 0, 255, 1'b0));
      send_req(clock_req(KIND_SAMPLE, 0, 0, 0, 255, 1'b1));   // 24 h plus banked: overflow
      send_req(clock_req(KIND_STOP, 0, 0, 0, 0, 1'b0));
      send_req(clock_req(KIND_START, 12, 30, 30, 128, 1'b0));
      send_req(clock_req(KIND_SAMPLE, 12, 30, 31, 100, 1'b0));
      send_req(clock_req(KIND_RESUME, 12, 31, 0, 200, 1'b0)); // resume while running
      send_req(clock_req(KIND_SAMPLE, 12, 31, 0, 230, 1'b0));
      send_req(clock_req(KIND_SAMPLE, 11, 0, 0, 0, 1'b0));    // clock went back: wraps
      send_req(clock_req(3'd5, 31, 63, 63, 255, 1'b1));
      send_req(clock_req(3'd6, 0, 0, 0, 0, 1'b0));
      send_req(clock_req(3'd7, 21, 42, 21, 170, 1'b1));
      send_req(clock_req(KIND_START, 31, 63, 63, 0, 1'b0));   // fields out of range
      send_req(clock_req(KIND_SAMPLE, 31, 63, 63, 0, 1'b1));
      send_req(clock_req(KIND_STOP, 0, 0, 0, 0, 1'b0));
      send_req(clock_req(KIND_RESUME, 7, 0, 0, 255, 1'b0));   // resume from idle
      send_req(clock_req(KIND_SAMPLE, 7, 59, 59, 25, 1'b0));
      send_req(clock_req(KIND_STOP, 0, 0, 0, 0, 1'b0));

      counted_items = 0;
      while (counted_items < RANDOM_ITEMS) begin
         if (!drained && counted_items > RANDOM_ITEMS / 2) begin
            drain_responses();
            drained = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_req(noise_req());
         end else begin
            run_session();
         end
      end

      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("stopwatch_elapsed_time_top_tb OK");
      end else begin
         $display("stopwatch_elapsed_time_top_tb NOT OK");
      end
      $finish;
   end

endmodule
